// File: rtl/pal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes of the positional array list
// Request kinds, status codes and the control word that the list
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [STATUS_W-1:0] t_status;

    // Request kinds.
    localparam t_kind KIND_CLEAR     = 3'd0;
    localparam t_kind KIND_APPEND    = 3'd1;
    localparam t_kind KIND_INSERT    = 3'd2;
    localparam t_kind KIND_DELETE    = 3'd3;
    localparam t_kind KIND_OVERWRITE = 3'd4;
    localparam t_kind KIND_READ      = 3'd5;

    // Result status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

    // What a cell does in one cycle.
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD  = 2'd0;
    localparam t_cell_op CELL_WRITE = 2'd1;   // the cell at the slot loads the value
    localparam t_cell_op CELL_INS   = 2'd2;   // slot loads value, cells above shift up
    localparam t_cell_op CELL_DEL   = 2'd3;   // slot and cells above shift down

    typedef struct packed {
        t_cell_op op;
        t_word    value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// File: rtl/pal_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pal_cell: one storage cell of the list
// Holds one word and takes it from its lower neighbor, its upper neighbor
// or the broadcast value, as the control word and its own index decide.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire logic                i_clk,
    input  wire pal_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [IW-1:0]       i_slot,
    input  wire pal_pkg::t_word      i_left,
    input  wire pal_pkg::t_word      i_right,
    output pal_pkg::t_word           o_word
);
    import pal_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        case (i_ctrl.op)
            CELL_WRITE: begin
                if (MY_IDX == i_slot) begin
                    n_word = i_ctrl.value;
                end
            end
            CELL_INS: begin
                if (MY_IDX == i_slot) begin
                    n_word = i_ctrl.value;
                end else if (MY_IDX > i_slot) begin
                    n_word = i_left;
                end
            end
            CELL_DEL: begin
                // The topmost cell takes zero, which clears the vacated cell.
                if (MY_IDX >= i_slot) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

// File: rtl/positional_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_array_list: ordered list of unsigned 32-bit words addressed by position
// A row of shift cells holding up to DEPTH words, with a controller that
// appends, inserts, deletes, overwrites, reads by 1-based position and clears.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the slave stream. tuser carries the kind (clear, append,
// insert, delete, overwrite, read); tdata carries the position in its low
// byte and the 32-bit value above it. Every request yields exactly one
// response on the master stream with the status, the word read (zero unless
// a read succeeds), the entry count after the request and an empty flag.
// Responses are registered and show in the cycle after their request is
// accepted. Throughput is one request per cycle while the receiver takes each
// response, set by the cell row, in which all cells shift together so that
// an insert or a delete finishes in the cycle it is accepted. The response
// register frees itself when the response is taken, so a new request is
// accepted in the same cycle as the previous response leaves. When the
// receiver stalls, the response holds and tready drops until it is taken.
// Reset empties the list and drops any pending response; the cell contents
// are not cleared, since a word is only read after it has been written.
// ----------------------------------------------------------------------------
module positional_array_list #(
    parameter int DEPTH = 64,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_TW = ((35 + CW + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Request stream.
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [39:0]       i_s_tdata,   // position[7:0], value[39:8]
    input  wire logic [2:0]        i_s_tuser,   // kind[2:0]
    // Response stream.
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [OUT_TW-1:0]      o_m_tdata    // status, read_data, entry_count,
                                                // is_empty, zero padding
);
    import pal_pkg::*;

    // Slot index width and a width that holds both positions and counts.
    localparam int IW = $clog2(DEPTH);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // Request fields.
    t_kind            kind;
    logic [POS_W-1:0] pos;
    t_word            value;
    assign kind  = i_s_tuser;
    assign pos   = i_s_tdata[POS_W-1:0];
    assign value = i_s_tdata[POS_W +: WORD_W];

    // List state.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Response register.
    logic          r_m_valid;
    t_status       r_status;
    t_word         r_rdata;
    logic [CW-1:0] r_count_out;
    logic          r_is_empty;

    logic accept;
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Position checks. The position is 1-based; the slot is 0-based.
    logic          is_full;
    logic          is_empty_now;
    logic          in_range;
    logic          ins_range;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic [IW-1:0] pos_slot;

    assign is_full      = (r_count == FULL_COUNT);
    assign is_empty_now = (r_count == '0);
    assign pos_w        = PW'(pos);
    assign cnt_w        = PW'(r_count);
    assign in_range     = (pos != '0) && (pos_w <= cnt_w);
    assign ins_range    = (pos != '0) && (pos_w <= cnt_w + PW'(1));
    assign pos_slot     = IW'(pos_w - PW'(1));

    // Cell row.
    t_word         cell_word [DEPTH];
    t_cell_ctrl    ctrl;
    logic [IW-1:0] slot;
    t_status       n_status;
    logic          rd_hit;
    t_word         rd_word;

    // Decode of the request into a cell command and a status.
    always_comb begin
        ctrl.op    = CELL_HOLD;
        ctrl.value = value;
        slot       = pos_slot;
        n_status   = ST_OK;
        n_count    = r_count;
        rd_hit     = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                n_count = '0;
            end
            KIND_APPEND: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.op = CELL_WRITE;
                    slot    = IW'(r_count);
                    n_count = r_count + CW'(1);
                end
            end
            KIND_INSERT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else if (!ins_range) begin
                    n_status = ST_RANGE;
                end else begin
                    ctrl.op = CELL_INS;
                    n_count = r_count + CW'(1);
                end
            end
            KIND_DELETE: begin
                if (is_empty_now) begin
                    n_status = ST_EMPTY;
                end else if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    ctrl.op = CELL_DEL;
                    n_count = r_count - CW'(1);
                end
            end
            KIND_OVERWRITE: begin
                if (is_empty_now) begin
                    n_status = ST_EMPTY;
                end else if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    ctrl.op = CELL_WRITE;
                end
            end
            KIND_READ: begin
                if (is_empty_now) begin
                    n_status = ST_EMPTY;
                end else if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    rd_hit = 1'b1;
                end
            end
            default: begin
                // Unused kinds change nothing and report success.
                n_status = ST_OK;
            end
        endcase
        // The cells only move on an accepted request.
        if (!accept) begin
            ctrl.op = CELL_HOLD;
        end
    end

    // Each cell hands its word to both neighbors; the row ends take zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_word;
        t_word right_word;
        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_word[g+1];
        end
        pal_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_slot  (slot),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (cell_word[g])
        );
    end

    // Read selection: the cell at the slot drives the word, all others zero.
    always_comb begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (pos_slot == IW'(i)) begin
                rd_word = rd_word | cell_word[i];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Response payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_rdata     <= rd_hit ? rd_word : '0;
            r_count_out <= n_count;
            r_is_empty  <= (n_count == '0);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TW'({r_is_empty, r_count_out, r_rdata, r_status});

    // The list never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count exceeds the cell count");

    // An accepted request always leaves a response behind.
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_m_valid)
        else $error("accepted request produced no response");

    // A successful append or insert grows the list by exactly one.
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (kind == KIND_APPEND || kind == KIND_INSERT) && n_status == ST_OK
        |=> r_count == $past(r_count) + CW'(1))
        else $error("append or insert did not grow the list by one");

    // Clear always empties the list.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && kind == KIND_CLEAR |=> r_count == '0 && r_is_empty)
        else $error("clear left entries counted");

    // The response count matches the list count while a response waits.
    a_resp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> r_count_out == r_count && r_is_empty == (r_count == '0))
        else $error("response count disagrees with the list");

endmodule
`default_nettype wire
